// File: rtl/bfre_pkg.sv
// package for the bitmap free run extractor
// item types, the front-to-back run descriptor and fixed widths; no dependencies
`default_nettype none

package bfre_pkg;

    localparam int CLUSTER_BITS  = 40;
    localparam int BITS_PER_BYTE = 8;
    // end positions run from bit 0 up to one past bit 7 (flush at byte end)
    localparam int END_BITS      = BITS_PER_BYTE + 1;
    localparam int POS_W         = $clog2(END_BITS);

    localparam logic [CLUSTER_BITS-1:0] COUNT_RESET = '1;

    typedef struct packed {
        logic [7:0] bitmap_byte;
        logic       first;
    } bfre_in_t;

    typedef struct packed {
        logic [CLUSTER_BITS-1:0] run_start;
        logic [CLUSTER_BITS:0]   run_length;
        logic                    last;
    } bfre_out_t;

    // one byte's worth of free runs, as bit positions relative to base
    typedef struct packed {
        logic [CLUSTER_BITS-1:0]  base;
        logic [CLUSTER_BITS-1:0]  carry_start;
        logic [CLUSTER_BITS:0]    carry_length;
        logic                     carry_free;
        logic [BITS_PER_BYTE-1:0] start_mask;
        logic [END_BITS-1:0]      end_mask;
    } bfre_desc_t;

endpackage

`default_nettype wire

// File: rtl/bitmap_free_run_extractor_unit.sv
// top level of the bitmap free run extractor
// ties front, descriptor queue and back together; depends on bfre_pkg and its submodules
//
// usage
//   in channel (in_valid/in_ready/in_item): one allocation bitmap byte per item,
//   bit 0 first, 1 = allocated; first = 1 restarts the scan at cluster 0
//   out channel (out_valid/out_ready/out_item): one finished free run per item,
//   with last set on the final run caused by a given input item
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes cluster_count, always
//   ready; write it only while the block is idle
// timing
//   the front classifies a byte in the cycle it is accepted and queues one
//   descriptor per byte that ends a run; the back emits one run per cycle unless
//   out_ready holds it; a first run passes the queue slot, the back's descriptor
//   registers and then the output register
//   a byte yields up to 5 runs: an alternating byte that also hits the cluster count
//   bytes that end no run are not queued and never reach the back
// reset
//   cluster_count returns to all ones, the scan to cluster 0, allocated state;
//   the queue and output register empty; no clearing pass
// stalls
//   out_ready low holds the output register; the back stops, the queue fills
//   and only then in_ready drops
`default_nettype none

module bitmap_free_run_extractor_unit
    import bfre_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CLUSTER_BITS-1:0] cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire bfre_in_t                in_item,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output bfre_out_t                    out_item
);

    // front to queue
    logic       queue_full;
    logic       push;
    bfre_desc_t push_desc;

    // queue to back
    logic       head_valid;
    bfre_desc_t head_desc;
    logic       pop;

    // register writes never stall
    assign cfg_ready = 1'b1;

    bfre_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .in_ready   (in_ready),
        .queue_full (queue_full),
        .push       (push),
        .desc       (push_desc)
    );

    // decouples byte acceptance from run emission
    bfre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    bfre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

`default_nettype wire

// File: rtl/bfre_front.sv
// front part: accepts bitmap items, tracks the scan and builds run descriptors
// depends on bfre_pkg
`default_nettype none

module bfre_front
    import bfre_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    input  wire logic [CLUSTER_BITS-1:0] cfg_data,
    input  wire logic                    in_valid,
    input  wire bfre_in_t                in_item,
    output logic                         in_ready,
    input  wire logic                    queue_full,
    output logic                         push,
    output bfre_desc_t                   desc
);

    logic [CLUSTER_BITS-1:0] count_reg;
    logic [CLUSTER_BITS-1:0] next_reg, next_next;
    logic [CLUSTER_BITS:0]   len_reg, len_next;
    logic                    alloc_reg, alloc_next;
    logic                    finished_reg, finished_next;

    logic [CLUSTER_BITS-1:0] base;
    logic [CLUSTER_BITS:0]   len;
    logic                    alloc;
    logic                    fin;
    logic                    eff_alloc;
    logic [CLUSTER_BITS:0]   diff;
    logic [POS_W-1:0]        n_cnt;
    logic                    finish;
    logic [7:0]              b;
    logic                    prev;
    logic                    in_b;
    logic                    last_bit;
    logic                    any_t;
    logic [POS_W-1:0]        last_t;
    logic [BITS_PER_BYTE-1:0] smask;
    logic [END_BITS-1:0]     emask;
    logic                    accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        b         = in_item.bitmap_byte;
        base      = in_item.first ? '0 : next_reg;
        len       = in_item.first ? '0 : len_reg;
        alloc     = in_item.first ? 1'b1 : alloc_reg;
        fin       = in_item.first ? 1'b0 : finished_reg;
        // an empty run behaves as allocated: nothing to emit when it closes
        eff_alloc = alloc || (len == '0);

        diff = {1'b0, count_reg} - {1'b0, base};
        if (diff[CLUSTER_BITS] || diff == '0)
        begin
            n_cnt  = '0;
            finish = 1'b1;
        end
        else if (diff > (CLUSTER_BITS+1)'(BITS_PER_BYTE))
        begin
            n_cnt  = POS_W'(BITS_PER_BYTE);
            finish = 1'b0;
        end
        else
        begin
            n_cnt  = diff[POS_W-1:0];
            finish = 1'b1;
        end

        smask    = '0;
        emask    = '0;
        any_t    = 1'b0;
        last_t   = '0;
        last_bit = eff_alloc;
        for (int i = 0; i < BITS_PER_BYTE; i++)
        begin
            prev = (i == 0) ? eff_alloc : b[i-1];
            in_b = POS_W'(i) < n_cnt;
            smask[i] = in_b && !b[i] && prev;
            emask[i] = in_b && b[i] && !prev;
            if (in_b)
            begin
                last_bit = b[i];
                if (b[i] != prev)
                begin
                    any_t  = 1'b1;
                    last_t = POS_W'(i);
                end
            end
        end
        // flush of a free run when the count is reached
        if (finish && !last_bit)
        begin
            emask[n_cnt] = 1'b1;
        end

        desc.base         = base;
        desc.carry_start  = base - len[CLUSTER_BITS-1:0];
        desc.carry_length = len;
        desc.carry_free   = !eff_alloc;
        desc.start_mask   = smask;
        desc.end_mask     = emask;

        push = accept && !fin && (emask != '0);

        next_next     = next_reg;
        len_next      = len_reg;
        alloc_next    = alloc_reg;
        finished_next = finished_reg;
        if (accept && !fin)
        begin
            next_next = base + CLUSTER_BITS'(n_cnt);
            if (finish)
            begin
                finished_next = 1'b1;
                len_next      = '0;
                alloc_next    = alloc;
            end
            else
            begin
                finished_next = 1'b0;
                alloc_next    = b[BITS_PER_BYTE-1];
                len_next      = any_t ? (CLUSTER_BITS+1)'(BITS_PER_BYTE) -
                                        (CLUSTER_BITS+1)'(last_t)
                                      : len + (CLUSTER_BITS+1)'(BITS_PER_BYTE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= COUNT_RESET;
            next_reg     <= '0;
            len_reg      <= '0;
            alloc_reg    <= 1'b1;
            finished_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                count_reg <= cfg_data;
            end
            next_reg     <= next_next;
            len_reg      <= len_next;
            alloc_reg    <= alloc_next;
            finished_reg <= finished_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bfre_queue.sv
// short descriptor queue between the front and back parts
// depends on bfre_pkg
`default_nettype none

module bfre_queue
    import bfre_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire bfre_desc_t push_desc,
    input  wire logic       pop,
    output logic            full,
    output logic            head_valid,
    output bfre_desc_t      head_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bfre_desc_t        slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, rd_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign full       = cnt_reg == CNT_W'(DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_desc  = slots_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/bfre_back.sv
// back part: walks one descriptor, one free run per cycle unless out_ready stalls,
// into the output register; depends on bfre_pkg
`default_nettype none

module bfre_back
    import bfre_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire bfre_desc_t head_desc,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output bfre_out_t       out_item
);

    function automatic logic [POS_W-1:0] lowest(input logic [END_BITS-1:0] m);
        logic [POS_W-1:0] idx;
        idx = '0;
        for (int i = END_BITS - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = POS_W'(i);
            end
        end
        return idx;
    endfunction

    logic                     busy_reg;
    logic                     carry_reg;
    logic [BITS_PER_BYTE-1:0] smask_reg;
    logic [END_BITS-1:0]      emask_reg;
    logic [CLUSTER_BITS-1:0]  base_reg;
    logic [CLUSTER_BITS-1:0]  cstart_reg;
    logic [CLUSTER_BITS:0]    clen_reg;
    logic                     out_valid_reg;
    bfre_out_t                out_reg;

    logic                     advance;
    logic                     emit;
    logic                     is_last;
    logic                     load;
    logic [POS_W-1:0]         e_pos, s_pos;
    logic [END_BITS-1:0]      emask_rest;
    logic [BITS_PER_BYTE-1:0] smask_rest;
    bfre_out_t                run;

    always_comb
    begin
        advance    = !out_valid_reg || out_ready;
        emit       = busy_reg && advance;
        e_pos      = lowest(emask_reg);
        s_pos      = lowest({1'b0, smask_reg});
        emask_rest = emask_reg & (emask_reg - 1'b1);
        smask_rest = smask_reg & (smask_reg - 1'b1);
        is_last    = emask_rest == '0;
        load       = head_valid && (!busy_reg || (emit && is_last));

        run.last = is_last;
        if (carry_reg)
        begin
            run.run_start  = cstart_reg;
            run.run_length = clen_reg + (CLUSTER_BITS+1)'(e_pos);
        end
        else
        begin
            run.run_start  = base_reg + CLUSTER_BITS'(s_pos);
            run.run_length = (CLUSTER_BITS+1)'(e_pos - s_pos);
        end
    end

    assign pop       = load;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= run;
        end
        if (load)
        begin
            smask_reg  <= head_desc.start_mask;
            emask_reg  <= head_desc.end_mask;
            base_reg   <= head_desc.base;
            cstart_reg <= head_desc.carry_start;
            clen_reg   <= head_desc.carry_length;
        end
        else if (emit)
        begin
            emask_reg <= emask_rest;
            if (!carry_reg)
            begin
                smask_reg <= smask_rest;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            carry_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= emit;
            end
            if (load)
            begin
                busy_reg  <= 1'b1;
                carry_reg <= head_desc.carry_free;
            end
            else if (emit)
            begin
                carry_reg <= 1'b0;
                if (is_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire
